// ===== src/bmhq_pkg.sv =====
// shared constants, codes and sequencer state type for the min-heap queue
package bmhq_pkg;

    // defaults for the top-level parameters
    localparam int DEF_CAPACITY = 1024;
    localparam int DEF_ID_SPACE = 1024;
    localparam int DEF_KEY_BITS = 32;

    // fixed port field widths
    localparam int KIND_W   = 2;
    localparam int ID_W     = 10;
    localparam int KEY_W    = 32;
    localparam int DELTA_W  = 31;
    localparam int STATUS_W = 3;
    localparam int TOTAL_W  = 11;

    // operation codes
    localparam logic [KIND_W-1:0] K_INSERT   = 2'd0;
    localparam logic [KIND_W-1:0] K_DEL_MIN  = 2'd1;
    localparam logic [KIND_W-1:0] K_DECREASE = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_ABSENT  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_PRESENT = 3'd4;

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_INS_CHK,
        S_DEC_CHK,
        S_DEC_KEY,
        S_UP,
        S_UP_CMP,
        S_DEL_ROOT,
        S_DEL_LAST,
        S_DN_RD,
        S_DN_L,
        S_DN_R,
        S_DN_CMP,
        S_DEL_CLR,
        S_MIN_RD,
        S_MIN
    } state_t;

endpackage

// ===== src/bmhq_slot_ram.sv =====
// heap slot memory holding (key, id) per slot, one write and one registered read port
module bmhq_slot_ram #(
    parameter int CAPACITY = bmhq_pkg::DEF_CAPACITY,
    parameter int KEY_BITS = bmhq_pkg::DEF_KEY_BITS,
    parameter int SW       = $clog2(CAPACITY + 1)
) (
    input  logic                             clk,
    input  logic                             wr_en,
    input  logic [SW-1:0]                    wr_addr,
    input  logic signed [KEY_BITS-1:0]       wr_key,
    input  logic [bmhq_pkg::ID_W-1:0]        wr_id,
    input  logic [SW-1:0]                    rd_addr,
    output logic signed [KEY_BITS-1:0]       rd_key,
    output logic [bmhq_pkg::ID_W-1:0]        rd_id
);
    import bmhq_pkg::*;

    logic signed [KEY_BITS-1:0] key_mem [CAPACITY+1];
    logic [ID_W-1:0]            id_mem  [CAPACITY+1];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            key_mem[wr_addr] <= wr_key;
            id_mem[wr_addr]  <= wr_id;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rd_key <= key_mem[rd_addr];
        rd_id  <= id_mem[rd_addr];
    end

endmodule

// ===== src/bmhq_pos_ram.sv =====
// id to slot position map, cleared by a sweep after reset
module bmhq_pos_ram #(
    parameter int ID_SPACE = bmhq_pkg::DEF_ID_SPACE,
    parameter int SW       = 11,
    parameter int IW       = $clog2(ID_SPACE)
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  logic [IW-1:0] wr_addr,
    input  logic [SW-1:0] wr_data,
    input  logic [IW-1:0] rd_addr,
    output logic [SW-1:0] rd_data,
    output logic          clr_busy
);
    import bmhq_pkg::*;

    logic [SW-1:0] pos_mem [ID_SPACE];
    logic [IW:0]   clr_cnt_reg;
    logic [IW:0]   clr_cnt_next;

    // clearing sweep counter
    assign clr_busy     = (clr_cnt_reg < (IW+1)'(ID_SPACE));
    assign clr_cnt_next = clr_busy ? clr_cnt_reg + 1'b1 : clr_cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else
        begin
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    // write port, sweep has priority
    always_ff @(posedge clk)
    begin
        if (clr_busy)
        begin
            pos_mem[clr_cnt_reg[IW-1:0]] <= '0;
        end
        else if (wr_en)
        begin
            pos_mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rd_data <= pos_mem[rd_addr];
    end

endmodule

// ===== src/binary_min_heap_queue.sv =====
// binary min-heap priority queue with decrease-key, top level and sequencer
//
// One operation at a time: a beat is taken on the input, walked through the heap by a small
// sequencer, and one result beat is offered at the output.
// The heap slot store and the id position map each have one write port and one registered
// read port. On the way up each heap level takes a parent read and a compare; on the way down
// it takes the left read, the right read when there is a right child, the child pick and a
// compare. A walk moves at most log2(CAPACITY) levels, 10 at the default size.
// in_stall stays high while an operation is in flight and, after reset, while the position
// map is swept to zero. A finished result sits in the output register until taken.
module binary_min_heap_queue #(
    parameter int CAPACITY = bmhq_pkg::DEF_CAPACITY,
    parameter int ID_SPACE = bmhq_pkg::DEF_ID_SPACE,
    parameter int KEY_BITS = bmhq_pkg::DEF_KEY_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [bmhq_pkg::KIND_W-1:0]         kind,
    input  logic [bmhq_pkg::ID_W-1:0]           item_id,
    input  logic signed [bmhq_pkg::KEY_W-1:0]   new_key,
    input  logic [bmhq_pkg::DELTA_W-1:0]        delta,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [bmhq_pkg::STATUS_W-1:0]       status,
    output logic                                popped_valid,
    output logic signed [bmhq_pkg::KEY_W-1:0]   popped_key,
    output logic [bmhq_pkg::ID_W-1:0]           popped_id,
    output logic                                min_valid,
    output logic signed [bmhq_pkg::KEY_W-1:0]   min_key,
    output logic [bmhq_pkg::ID_W-1:0]           min_id,
    output logic [bmhq_pkg::TOTAL_W-1:0]        entry_total
);
    import bmhq_pkg::*;

    localparam int SW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(ID_SPACE);
    localparam int XW = ((KEY_BITS > DELTA_W) ? KEY_BITS : DELTA_W) + 2;
    localparam logic signed [XW-1:0] KMIN =
        {{(XW-KEY_BITS+1){1'b1}}, {(KEY_BITS-1){1'b0}}};
    localparam logic signed [XW-1:0] KMAX = ~KMIN;

    // sequencer and datapath registers
    state_t                     state_reg, state_next;
    logic [SW-1:0]              count_reg, count_next;
    logic [SW-1:0]              s_reg, s_next;
    logic [SW-1:0]              d_reg, d_next;
    logic signed [KEY_BITS-1:0] key_reg, key_next;
    logic [ID_W-1:0]            id_reg, id_next;
    logic [DELTA_W-1:0]         delta_reg, delta_next;
    logic signed [KEY_BITS-1:0] ch_key_reg, ch_key_next;
    logic [ID_W-1:0]            ch_id_reg, ch_id_next;
    logic [STATUS_W-1:0]        st_reg, st_next;
    logic                       pop_v_reg, pop_v_next;
    logic signed [KEY_BITS-1:0] pop_key_reg, pop_key_next;
    logic [ID_W-1:0]            pop_id_reg, pop_id_next;
    logic                       out_valid_reg;

    // memory ports
    logic                       slot_we;
    logic [SW-1:0]              slot_waddr, slot_raddr;
    logic signed [KEY_BITS-1:0] slot_wkey, slot_rkey;
    logic [ID_W-1:0]            slot_wid, slot_rid;
    logic                       pos_we;
    logic [IW-1:0]              pos_waddr, pos_raddr;
    logic [SW-1:0]              pos_wdata, pos_rdata;
    logic                       clr_busy;

    // helper terms
    logic                       in_fire;
    logic                       out_free;
    logic                       in_id_ok;
    logic signed [XW-1:0]       nk_x;
    logic signed [KEY_BITS-1:0] nk_clamp;
    logic signed [XW-1:0]       dec_x;
    logic signed [KEY_BITS-1:0] dec_key;
    logic [SW:0]                c_x;
    logic [SW:0]                r_x;
    logic [SW:0]                cnt_x;

    bmhq_slot_ram #(
        .CAPACITY (CAPACITY),
        .KEY_BITS (KEY_BITS),
        .SW       (SW)
    ) u_slot_ram (
        .clk     (clk),
        .wr_en   (slot_we),
        .wr_addr (slot_waddr),
        .wr_key  (slot_wkey),
        .wr_id   (slot_wid),
        .rd_addr (slot_raddr),
        .rd_key  (slot_rkey),
        .rd_id   (slot_rid)
    );

    bmhq_pos_ram #(
        .ID_SPACE (ID_SPACE),
        .SW       (SW),
        .IW       (IW)
    ) u_pos_ram (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (pos_we),
        .wr_addr  (pos_waddr),
        .wr_data  (pos_wdata),
        .rd_addr  (pos_raddr),
        .rd_data  (pos_rdata),
        .clr_busy (clr_busy)
    );

    // handshake
    assign in_stall  = (state_reg != S_IDLE) || clr_busy;
    assign in_fire   = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign in_id_ok  = (32'(item_id) < ID_SPACE);

    // clamp of an inserted key into the key range
    always_comb
    begin
        nk_x = XW'(new_key);
        if (nk_x > KMAX)
        begin
            nk_x = KMAX;
        end
        else if (nk_x < KMIN)
        begin
            nk_x = KMIN;
        end
        nk_clamp = KEY_BITS'(nk_x);
    end

    // saturating key decrease
    always_comb
    begin
        dec_x = XW'(slot_rkey) - XW'($signed({1'b0, delta_reg}));
        if (dec_x < KMIN)
        begin
            dec_x = KMIN;
        end
        dec_key = KEY_BITS'(dec_x);
    end

    // child addresses for sift-down
    assign c_x   = {s_reg, 1'b0};
    assign r_x   = c_x + 1'b1;
    assign cnt_x = {1'b0, count_reg};

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    if (kind == K_INSERT)
                    begin
                        state_next = in_id_ok ? S_INS_CHK : S_MIN_RD;
                    end
                    else if (kind == K_DECREASE)
                    begin
                        state_next = in_id_ok ? S_DEC_CHK : S_MIN_RD;
                    end
                    else if (kind == K_DEL_MIN)
                    begin
                        state_next = (count_reg == '0) ? S_MIN_RD : S_DEL_ROOT;
                    end
                    else
                    begin
                        state_next = S_MIN_RD;
                    end
                end
            end
            S_INS_CHK:
            begin
                if (pos_rdata != '0 || count_reg >= SW'(CAPACITY))
                begin
                    state_next = S_MIN_RD;
                end
                else
                begin
                    state_next = S_UP;
                end
            end
            S_DEC_CHK:
            begin
                if (pos_rdata == '0 || pos_rdata > count_reg)
                begin
                    state_next = S_MIN_RD;
                end
                else
                begin
                    state_next = S_DEC_KEY;
                end
            end
            S_DEC_KEY:  state_next = S_UP;
            S_UP:       state_next = (s_reg == SW'(1)) ? S_MIN_RD : S_UP_CMP;
            S_UP_CMP:   state_next = (key_reg < slot_rkey) ? S_UP : S_MIN_RD;
            S_DEL_ROOT: state_next = S_DEL_LAST;
            S_DEL_LAST: state_next = (count_reg == SW'(1)) ? S_DEL_CLR : S_DN_RD;
            S_DN_RD:    state_next = (c_x > cnt_x) ? S_DEL_CLR : S_DN_L;
            S_DN_L:     state_next = (r_x <= cnt_x) ? S_DN_R : S_DN_CMP;
            S_DN_R:     state_next = S_DN_CMP;
            S_DN_CMP:   state_next = (ch_key_reg < key_reg) ? S_DN_RD : S_DEL_CLR;
            S_DEL_CLR:  state_next = S_MIN_RD;
            S_MIN_RD:   state_next = S_MIN;
            S_MIN:      state_next = out_free ? S_IDLE : S_MIN;
            default:    state_next = S_IDLE;
        endcase
    end

    // memory control outputs
    always_comb
    begin
        slot_we    = 1'b0;
        slot_waddr = s_reg;
        slot_wkey  = key_reg;
        slot_wid   = id_reg;
        slot_raddr = SW'(1);
        pos_we     = 1'b0;
        pos_waddr  = IW'(id_reg);
        pos_wdata  = s_reg;
        pos_raddr  = IW'(item_id);
        unique case (state_reg)
            S_INS_CHK:  ;
            S_DEC_CHK:  slot_raddr = pos_rdata;
            S_UP:
            begin
                if (s_reg == SW'(1))
                begin
                    slot_we = 1'b1;
                    pos_we  = 1'b1;
                end
                else
                begin
                    slot_raddr = s_reg >> 1;
                end
            end
            S_UP_CMP:
            begin
                slot_we = 1'b1;
                pos_we  = 1'b1;
                if (key_reg < slot_rkey)
                begin
                    slot_wkey = slot_rkey;
                    slot_wid  = slot_rid;
                    pos_waddr = IW'(slot_rid);
                end
            end
            S_DEL_ROOT: slot_raddr = count_reg;
            S_DN_RD:
            begin
                if (c_x > cnt_x)
                begin
                    slot_we = 1'b1;
                    pos_we  = 1'b1;
                end
                else
                begin
                    slot_raddr = SW'(c_x);
                end
            end
            S_DN_L:     slot_raddr = SW'(r_x);
            S_DN_CMP:
            begin
                slot_we = 1'b1;
                pos_we  = 1'b1;
                if (ch_key_reg < key_reg)
                begin
                    slot_wkey = ch_key_reg;
                    slot_wid  = ch_id_reg;
                    pos_waddr = IW'(ch_id_reg);
                end
            end
            S_DEL_CLR:
            begin
                pos_we    = 1'b1;
                pos_waddr = IW'(pop_id_reg);
                pos_wdata = '0;
            end
            default:    ;
        endcase
    end

    // datapath register next values
    always_comb
    begin
        count_next   = count_reg;
        s_next       = s_reg;
        d_next       = d_reg;
        key_next     = key_reg;
        id_next      = id_reg;
        delta_next   = delta_reg;
        ch_key_next  = ch_key_reg;
        ch_id_next   = ch_id_reg;
        st_next      = st_reg;
        pop_v_next   = pop_v_reg;
        pop_key_next = pop_key_reg;
        pop_id_next  = pop_id_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    key_next   = nk_clamp;
                    id_next    = item_id;
                    delta_next = delta;
                    pop_v_next = 1'b0;
                    st_next    = ST_OK;
                    if ((kind == K_INSERT || kind == K_DECREASE) && !in_id_ok)
                    begin
                        st_next = ST_ABSENT;
                    end
                    else if (kind == K_DEL_MIN && count_reg == '0)
                    begin
                        st_next = ST_EMPTY;
                    end
                end
            end
            S_INS_CHK:
            begin
                if (pos_rdata != '0)
                begin
                    st_next = ST_PRESENT;
                end
                else if (count_reg >= SW'(CAPACITY))
                begin
                    st_next = ST_FULL;
                end
                else
                begin
                    count_next = count_reg + 1'b1;
                    s_next     = count_reg + 1'b1;
                end
            end
            S_DEC_CHK:
            begin
                if (pos_rdata == '0 || pos_rdata > count_reg)
                begin
                    st_next = ST_ABSENT;
                end
                else
                begin
                    s_next = pos_rdata;
                end
            end
            S_DEC_KEY:  key_next = dec_key;
            S_UP_CMP:
            begin
                if (key_reg < slot_rkey)
                begin
                    s_next = s_reg >> 1;
                end
            end
            S_DEL_ROOT:
            begin
                pop_v_next   = 1'b1;
                pop_key_next = slot_rkey;
                pop_id_next  = slot_rid;
            end
            S_DEL_LAST:
            begin
                key_next   = slot_rkey;
                id_next    = slot_rid;
                count_next = count_reg - 1'b1;
                s_next     = SW'(1);
            end
            S_DN_L:
            begin
                ch_key_next = slot_rkey;
                ch_id_next  = slot_rid;
                d_next      = SW'(c_x);
            end
            S_DN_R:
            begin
                if (!(ch_key_reg <= slot_rkey))
                begin
                    ch_key_next = slot_rkey;
                    ch_id_next  = slot_rid;
                    d_next      = SW'(r_x);
                end
            end
            S_DN_CMP:
            begin
                if (ch_key_reg < key_reg)
                begin
                    s_next = d_reg;
                end
            end
            default:    ;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (state_reg == S_MIN && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        s_reg       <= s_next;
        d_reg       <= d_next;
        key_reg     <= key_next;
        id_reg      <= id_next;
        delta_reg   <= delta_next;
        ch_key_reg  <= ch_key_next;
        ch_id_reg   <= ch_id_next;
        st_reg      <= st_next;
        pop_v_reg   <= pop_v_next;
        pop_key_reg <= pop_key_next;
        pop_id_reg  <= pop_id_next;
    end

    // result beat register
    always_ff @(posedge clk)
    begin
        if (state_reg == S_MIN && out_free)
        begin
            status       <= st_reg;
            popped_valid <= pop_v_reg;
            popped_key   <= pop_v_reg ? KEY_W'(pop_key_reg) : '0;
            popped_id    <= pop_v_reg ? pop_id_reg : '0;
            min_valid    <= (count_reg != '0);
            min_key      <= (count_reg != '0) ? KEY_W'(slot_rkey) : '0;
            min_id       <= (count_reg != '0) ? slot_rid : '0;
            entry_total  <= TOTAL_W'(count_reg);
        end
    end

endmodule

// ===== src/bmhq_check.sv =====
// port-level checker for the min-heap queue, bound to the top level
module bmhq_check (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_valid,
    input logic                                in_stall,
    input logic                                out_valid,
    input logic                                out_stall,
    input logic [bmhq_pkg::STATUS_W-1:0]       status,
    input logic                                popped_valid,
    input logic                                min_valid,
    input logic [bmhq_pkg::TOTAL_W-1:0]        entry_total
);
    import bmhq_pkg::*;

    // a held result beat keeps its content
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) && $stable(entry_total))
        else $error("result beat changed while stalled");

    // one operation at a time
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken while an operation is in flight");

    // minimum present exactly when the heap holds entries
    a_min_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (min_valid == (entry_total != '0)))
        else $error("min_valid disagrees with entry_total");

    // a pop only with ok status
    a_pop_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && popped_valid |-> status == ST_OK)
        else $error("popped entry with error status");

    // delete on empty leaves an empty heap
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_EMPTY |-> entry_total == '0 && !popped_valid)
        else $error("empty status with entries held");

endmodule

bind binary_min_heap_queue bmhq_check u_bmhq_check (.*);
